// ===== hw/rtl/tfc_pkg.sv =====
// Shared types and constants for the TEA-family Feistel cipher engine.
package tfc_pkg;

    localparam int WORD_W   = 32;
    localparam int BLOCK_W  = 64;
    localparam int KEY_N    = 16;
    localparam int KEY_AW   = 4;
    localparam int CONST_N  = 64;
    localparam int CONST_AW = 6;
    localparam int OP_W     = 2;
    localparam int RC_W     = 6;

    localparam logic [OP_W-1:0] OP_ENCRYPT    = 2'd0;
    localparam logic [OP_W-1:0] OP_DECRYPT    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_KEY   = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD_CONST = 2'd3;

    localparam logic [RC_W-1:0] ROUND_COUNT_RESET = 6'd29;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic                en;
        logic [KEY_AW-1:0]   addr;
        t_word               data;
    } t_key_wr;

    typedef struct packed {
        logic subtract;
    } t_round_ctl;

endpackage

// ===== hw/rtl/tfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tfc_round_unit.sv =====
// Key word store and the shared half-round mix, add and subtract unit.
module tfc_round_unit
    import tfc_pkg::*;
(
    input  logic       i_clk,
    input  t_key_wr    i_key_wr,
    input  t_round_ctl i_ctl,
    input  t_word      i_src,
    input  t_word      i_tgt,
    input  t_word      i_const,
    output t_word      o_result
);

    t_word r_key [KEY_N];
    t_word w_sum;
    t_word w_fold;
    t_word w_mix;

    always_ff @(posedge i_clk) begin
        if (i_key_wr.en) begin
            r_key[i_key_wr.addr] <= i_key_wr.data;
        end
    end

    always_comb begin
        w_sum  = i_const + r_key[i_src[KEY_AW-1:0]];
        w_fold = i_src + ((i_src >> 5) ^ (i_src << 4));
        w_mix  = w_sum ^ w_fold;
        if (i_ctl.subtract) begin
            o_result = i_tgt - w_mix;
        end else begin
            o_result = i_tgt + w_mix;
        end
    end

endmodule

// ===== hw/rtl/tea_family_feistel_cipher_top.sv =====
// Top level of the TEA-family Feistel cipher engine: sequencer, round constant RAM, output register.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------
//   input    | i_valid / o_ready        | i_operation, i_index, i_data
//   output   | o_valid / i_ready        | o_block_out
//   config   | i_cfg_valid / o_cfg_ready| i_cfg_data (round count)
//
// A cipher item goes through S_PREP for the constant RAM read, S_RUN for 2*N half-rounds
// at one half-round per cycle through the shared round unit, N the round count capped at
// MAX_ROUNDS, and S_FIN to load the output; with N of zero, straight to S_FIN. Load items
// complete on acceptance. Reset is synchronous and active low; the key and constant
// stores are not cleared. A result held on a stalled output blocks the next cipher item
// from finishing; o_ready stays low from acceptance until the result is loaded.
module tea_family_feistel_cipher_top
    import tfc_pkg::*;
#(
    parameter int MAX_ROUNDS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [CONST_AW-1:0] i_index,
    input  logic [BLOCK_W-1:0]  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [BLOCK_W-1:0]  o_block_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RC_W-1:0]     i_cfg_data
);

    localparam int NMAX   = (MAX_ROUNDS < 63) ? MAX_ROUNDS : 63;
    localparam int STEP_W = $clog2(2 * NMAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIN
    } t_state;

    t_state                r_state, n_state;
    t_word                 r_hi, n_hi;
    t_word                 r_lo, n_lo;
    logic                  r_dec, n_dec;
    logic                  r_phase, n_phase;
    logic [STEP_W-1:0]     r_left, n_left;
    logic [CONST_AW-1:0]   r_caddr, n_caddr;
    logic                  r_out_valid, n_out_valid;
    logic [BLOCK_W-1:0]    r_block, n_block;
    logic [RC_W-1:0]       r_round_count;

    logic                  w_accept;
    logic                  w_cipher;
    logic [RC_W:0]         w_rounds;
    logic [RC_W+1:0]       w_halves;
    logic [CONST_AW-1:0]   w_dec_first;
    logic                  w_upd_hi;
    t_word                 w_const;
    t_word                 w_src;
    t_word                 w_tgt;
    t_word                 w_result;
    t_key_wr               w_key_wr;
    t_round_ctl            w_ctl;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_block_out = r_block;

    assign w_accept = i_valid && o_ready;
    assign w_cipher = (i_operation == OP_ENCRYPT) || (i_operation == OP_DECRYPT);

    always_comb begin
        w_rounds = {1'b0, r_round_count};
        if (w_rounds > (RC_W + 1)'(MAX_ROUNDS)) begin
            w_rounds = (RC_W + 1)'(MAX_ROUNDS);
        end
        w_halves    = {w_rounds, 1'b0};
        w_dec_first = w_halves[CONST_AW-1:0] - CONST_AW'(1);
    end

    assign w_key_wr.en   = w_accept && (i_operation == OP_LOAD_KEY);
    assign w_key_wr.addr = i_index[KEY_AW-1:0];
    assign w_key_wr.data = i_data[WORD_W-1:0];

    assign w_upd_hi     = ~(r_phase ^ r_dec);
    assign w_src        = w_upd_hi ? r_lo : r_hi;
    assign w_tgt        = w_upd_hi ? r_hi : r_lo;
    assign w_ctl.subtract = r_dec;

    tfc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CONST_N)
    ) u_const_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_operation == OP_LOAD_CONST)),
        .i_wr_addr (i_index),
        .i_wr_data (i_data[WORD_W-1:0]),
        .i_rd_addr (r_caddr),
        .o_rd_data (w_const)
    );

    tfc_round_unit u_round (
        .i_clk    (i_clk),
        .i_key_wr (w_key_wr),
        .i_ctl    (w_ctl),
        .i_src    (w_src),
        .i_tgt    (w_tgt),
        .i_const  (w_const),
        .o_result (w_result)
    );

    always_comb begin
        n_state     = r_state;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_dec       = r_dec;
        n_phase     = r_phase;
        n_left      = r_left;
        n_caddr     = r_caddr;
        n_block     = r_block;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_cipher) begin
                    n_dec   = (i_operation == OP_DECRYPT);
                    n_phase = 1'b0;
                    n_left  = STEP_W'(w_halves);
                    if (i_operation == OP_DECRYPT) begin
                        n_hi    = i_data[WORD_W-1:0];
                        n_lo    = i_data[BLOCK_W-1:WORD_W];
                        n_caddr = w_dec_first;
                    end else begin
                        n_hi    = i_data[BLOCK_W-1:WORD_W];
                        n_lo    = i_data[WORD_W-1:0];
                        n_caddr = '0;
                    end
                    n_state = (w_halves == '0) ? S_FIN : S_PREP;
                end
            end
            S_PREP: begin
                n_caddr = r_dec ? r_caddr - CONST_AW'(1) : r_caddr + CONST_AW'(1);
                n_state = S_RUN;
            end
            S_RUN: begin
                if (w_upd_hi) begin
                    n_hi = w_result;
                end else begin
                    n_lo = w_result;
                end
                n_phase = ~r_phase;
                n_left  = r_left - STEP_W'(1);
                n_caddr = r_dec ? r_caddr - CONST_AW'(1) : r_caddr + CONST_AW'(1);
                if (r_left == STEP_W'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_block     = r_dec ? {r_hi, r_lo} : {r_lo, r_hi};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_round_count <= ROUND_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_round_count <= i_cfg_data;
            end
        end
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_dec   <= n_dec;
        r_phase <= n_phase;
        r_left  <= n_left;
        r_caddr <= n_caddr;
        r_block <= n_block;
    end

endmodule
